// ===== rtl/lav_pkg.sv =====
// Shared types, widths and constants for the look-at view matrix block.
// No dependencies; every other file of the block imports this package.
package lav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;                 // external word width
  localparam int QW        = FRAC_BITS + 2;      // signed unit-vector component
  localparam int UUW       = QW + 1;             // up-axis component, with headroom
  localparam int VW        = DW + QW;            // vector entering a normalizer
  localparam int PW        = $clog2(VW);         // bit position in a magnitude
  localparam int MW        = 30;                 // scaled magnitude width
  localparam int LW        = MW + 1;             // vector length width
  localparam int SQW       = 64;                 // square-root working width
  localparam int SQSTEPS   = 32;                 // one result bit per step
  localparam int QBITS     = FRAC_BITS + 1;      // quotient bits of a unit component
  localparam int NUMW      = MW + FRAC_BITS + 1; // dividend width
  localparam int UPW       = 2 * QW;             // unit times unit product
  localparam int EPW       = DW + UUW;           // unit times eye product
  localparam int DOTW      = EPW + 2;            // sum of three eye products

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [QW-1:0] unit_t;
  typedef logic signed [VW-1:0] vec_t;

  typedef struct packed {
    word_t eye_x;
    word_t eye_y;
    word_t eye_z;
    word_t target_x;
    word_t target_y;
    word_t target_z;
    word_t upward_x;
    word_t upward_y;
    word_t upward_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0] row_index;
    word_t      element_a;
    word_t      element_b;
    word_t      element_c;
    logic       degenerate;
    logic       last_row;
  } out_item_t;

  // Data that rides along a normalizer without being touched by it.
  typedef struct packed {
    logic [2:0][DW-1:0] eye;
    logic [2:0][DW-1:0] up;
    logic [2:0][QW-1:0] fw;
    logic               degen;
  } side_t;

endpackage

// ===== rtl/look_at_view_matrix.sv =====
// Look-at view matrix builder: one eye/target/up item in, four matrix rows out.
// A new item can enter while earlier items are still in the pipeline, but every
// stage holds while the result register sends the four rows of its item.
// Reset (synchronous, rst_n low) clears all valid bits and the row count,
// and sets right_handed to 1. Depends on lav_pkg and lav_norm.
module look_at_view_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  lav_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lav_pkg::out_item_t  out_item
);
  import lav_pkg::*;

  // Rounds a fixed-point value right by FRAC_BITS, half away from zero.
  function automatic logic signed [DOTW-1:0] rnd_shift(input logic signed [DOTW-1:0] x);
    logic [DOTW-1:0] m;
    m = x[DOTW-1] ? DOTW'(-x) : DOTW'(x);
    m = (m + (DOTW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x[DOTW-1] ? -$signed(m) : $signed(m);
  endfunction

  // Negates a rounded dot product and saturates it to a 32-bit word.
  function automatic word_t sat_neg(input logic signed [DOTW-1:0] r);
    logic signed [DOTW-1:0] n;
    n = -r;
    if (n[DOTW-1:DW-1] == '0 || n[DOTW-1:DW-1] == '1) begin
      return n[DW-1:0];
    end
    return n[DOTW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  endfunction

  // The whole pipeline advances together. It moves whenever the result
  // register is empty or its last row is being transferred this cycle, so
  // a stall on the result side freezes every stage and loses nothing.
  logic       en;
  logic       fin_vld_r;
  logic [1:0] row_r;
  logic       rh_r;

  assign en       = !fin_vld_r || (!out_stall && row_r == 2'd3);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rh_r <= 1'b1;
    end else if (cfg_we) begin
      rh_r <= cfg_wdata;
    end
  end

  // Input stage: the forward direction before normalization.
  logic               a_vld_r;
  vec_t  [2:0]        a_vec_r, a_vec_nxt;
  side_t              a_side_r, a_side_nxt;
  logic signed [DW:0] dir [3];

  always_comb begin
    if (rh_r) begin
      dir[0] = $signed(in_item.target_x) - $signed(in_item.eye_x);
      dir[1] = $signed(in_item.target_y) - $signed(in_item.eye_y);
      dir[2] = $signed(in_item.target_z) - $signed(in_item.eye_z);
    end else begin
      dir[0] = $signed(in_item.eye_x) - $signed(in_item.target_x);
      dir[1] = $signed(in_item.eye_y) - $signed(in_item.target_y);
      dir[2] = $signed(in_item.eye_z) - $signed(in_item.target_z);
    end
    for (int i = 0; i < 3; i++) a_vec_nxt[i] = VW'(dir[i]);
    a_side_nxt.eye   = {in_item.eye_z, in_item.eye_y, in_item.eye_x};
    a_side_nxt.up    = {in_item.upward_z, in_item.upward_y, in_item.upward_x};
    a_side_nxt.fw    = '0;
    a_side_nxt.degen = 1'b0;
  end

  // Forward axis.
  logic         n1_vld;
  unit_t [2:0]  n1_unit;
  logic         n1_zero;
  side_t        n1_side;

  lav_norm u_norm_fwd (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (a_vld_r),
    .in_vec   (a_vec_r),
    .in_side  (a_side_r),
    .out_vld  (n1_vld),
    .out_unit (n1_unit),
    .out_zero (n1_zero),
    .out_side (n1_side)
  );

  // Cross product of the up hint with the forward axis: products, then
  // differences. Order of the products: yz, zy, zx, xz, xy, yx.
  logic                     c1_vld_r;
  logic signed [VW-1:0]     c1_p_r [6];
  logic signed [VW-1:0]     c1_p_nxt [6];
  side_t                    c1_side_r, c1_side_nxt;

  always_comb begin
    c1_p_nxt[0] = $signed(n1_side.up[1]) * $signed(n1_unit[2]);
    c1_p_nxt[1] = $signed(n1_side.up[2]) * $signed(n1_unit[1]);
    c1_p_nxt[2] = $signed(n1_side.up[2]) * $signed(n1_unit[0]);
    c1_p_nxt[3] = $signed(n1_side.up[0]) * $signed(n1_unit[2]);
    c1_p_nxt[4] = $signed(n1_side.up[0]) * $signed(n1_unit[1]);
    c1_p_nxt[5] = $signed(n1_side.up[1]) * $signed(n1_unit[0]);
    c1_side_nxt       = n1_side;
    c1_side_nxt.fw    = n1_unit;
    c1_side_nxt.degen = n1_zero;
  end

  logic         c2_vld_r;
  vec_t  [2:0]  c2_vec_r, c2_vec_nxt;
  side_t        c2_side_r;

  always_comb begin
    c2_vec_nxt[0] = c1_p_r[0] - c1_p_r[1];
    c2_vec_nxt[1] = c1_p_r[2] - c1_p_r[3];
    c2_vec_nxt[2] = c1_p_r[4] - c1_p_r[5];
  end

  // Side axis. A zero forward axis makes this cross product zero too.
  logic         n2_vld;
  unit_t [2:0]  n2_unit;
  logic         n2_zero;
  side_t        n2_side;

  lav_norm u_norm_side (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (c2_vld_r),
    .in_vec   (c2_vec_r),
    .in_side  (c2_side_r),
    .out_vld  (n2_vld),
    .out_unit (n2_unit),
    .out_zero (n2_zero),
    .out_side (n2_side)
  );

  // D1: products for the up axis and for the side and forward dot products.
  logic                     d1_vld_r;
  logic signed [UPW-1:0]    d1_fs_r [6];
  logic signed [UPW-1:0]    d1_fs_nxt [6];
  logic signed [EPW-1:0]    d1_se_r [3];
  logic signed [EPW-1:0]    d1_se_nxt [3];
  logic signed [EPW-1:0]    d1_fe_r [3];
  logic signed [EPW-1:0]    d1_fe_nxt [3];
  unit_t [2:0]              d1_sd_r, d1_fw_r;
  logic [2:0][DW-1:0]       d1_eye_r;
  logic                     d1_degen_r;

  always_comb begin
    // Up axis terms, same order as the cross product above, forward times side.
    d1_fs_nxt[0] = $signed(n2_side.fw[1]) * $signed(n2_unit[2]);
    d1_fs_nxt[1] = $signed(n2_side.fw[2]) * $signed(n2_unit[1]);
    d1_fs_nxt[2] = $signed(n2_side.fw[2]) * $signed(n2_unit[0]);
    d1_fs_nxt[3] = $signed(n2_side.fw[0]) * $signed(n2_unit[2]);
    d1_fs_nxt[4] = $signed(n2_side.fw[0]) * $signed(n2_unit[1]);
    d1_fs_nxt[5] = $signed(n2_side.fw[1]) * $signed(n2_unit[0]);
    for (int i = 0; i < 3; i++) begin
      d1_se_nxt[i] = $signed(n2_unit[i]) * $signed(n2_side.eye[i]);
      d1_fe_nxt[i] = $signed(n2_side.fw[i]) * $signed(n2_side.eye[i]);
    end
  end

  // D2: rounded up axis, side and forward dot sums.
  logic                     d2_vld_r;
  logic signed [UUW-1:0]    d2_uu_r [3];
  logic signed [UUW-1:0]    d2_uu_nxt [3];
  logic signed [DOTW-1:0]   d2_sdot_r, d2_fdot_r;
  logic signed [DOTW-1:0]   uu_diff [3];
  logic signed [DOTW-1:0]   uu_rnd  [3];
  unit_t [2:0]              d2_sd_r, d2_fw_r;
  logic [2:0][DW-1:0]       d2_eye_r;
  logic                     d2_degen_r;

  always_comb begin
    uu_diff[0] = d1_fs_r[0] - d1_fs_r[1];
    uu_diff[1] = d1_fs_r[2] - d1_fs_r[3];
    uu_diff[2] = d1_fs_r[4] - d1_fs_r[5];
    for (int i = 0; i < 3; i++) begin
      uu_rnd[i]    = rnd_shift(uu_diff[i]);
      d2_uu_nxt[i] = uu_rnd[i][UUW-1:0];
    end
  end

  // D3: up axis times eye.
  logic                     d3_vld_r;
  logic signed [EPW-1:0]    d3_ue_r [3];
  logic signed [EPW-1:0]    d3_ue_nxt [3];
  logic signed [DOTW-1:0]   d3_sdot_r, d3_fdot_r;
  logic signed [UUW-1:0]    d3_uu_r [3];
  unit_t [2:0]              d3_sd_r, d3_fw_r;
  logic                     d3_degen_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d3_ue_nxt[i] = $signed(d2_uu_r[i]) * $signed(d2_eye_r[i]);
    end
  end

  // D4: up axis dot sum.
  logic                     d4_vld_r;
  logic signed [DOTW-1:0]   d4_sdot_r, d4_udot_r, d4_fdot_r;
  logic signed [UUW-1:0]    d4_uu_r [3];
  unit_t [2:0]              d4_sd_r, d4_fw_r;
  logic                     d4_degen_r;

  // Final stage: the whole matrix of one item, read out row by row.
  word_t                    fin_tr_r [3];
  logic signed [UUW-1:0]    fin_uu_r [3];
  unit_t [2:0]              fin_sd_r, fin_fw_r;
  logic                     fin_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      c1_vld_r  <= 1'b0;
      c2_vld_r  <= 1'b0;
      d1_vld_r  <= 1'b0;
      d2_vld_r  <= 1'b0;
      d3_vld_r  <= 1'b0;
      d4_vld_r  <= 1'b0;
      fin_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r   <= in_valid;
      c1_vld_r  <= n1_vld;
      c2_vld_r  <= c1_vld_r;
      d1_vld_r  <= n2_vld;
      d2_vld_r  <= d1_vld_r;
      d3_vld_r  <= d2_vld_r;
      d4_vld_r  <= d3_vld_r;
      fin_vld_r <= d4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_vec_r  <= a_vec_nxt;
      a_side_r <= a_side_nxt;

      c1_p_r    <= c1_p_nxt;
      c1_side_r <= c1_side_nxt;
      c2_vec_r  <= c2_vec_nxt;
      c2_side_r <= c1_side_r;

      d1_fs_r    <= d1_fs_nxt;
      d1_se_r    <= d1_se_nxt;
      d1_fe_r    <= d1_fe_nxt;
      d1_sd_r    <= n2_unit;
      d1_fw_r    <= n2_side.fw;
      d1_eye_r   <= n2_side.eye;
      d1_degen_r <= n2_side.degen | n2_zero;

      d2_uu_r    <= d2_uu_nxt;
      d2_sdot_r  <= DOTW'(d1_se_r[0]) + DOTW'(d1_se_r[1]) + DOTW'(d1_se_r[2]);
      d2_fdot_r  <= DOTW'(d1_fe_r[0]) + DOTW'(d1_fe_r[1]) + DOTW'(d1_fe_r[2]);
      d2_sd_r    <= d1_sd_r;
      d2_fw_r    <= d1_fw_r;
      d2_eye_r   <= d1_eye_r;
      d2_degen_r <= d1_degen_r;

      d3_ue_r    <= d3_ue_nxt;
      d3_sdot_r  <= d2_sdot_r;
      d3_fdot_r  <= d2_fdot_r;
      d3_uu_r    <= d2_uu_r;
      d3_sd_r    <= d2_sd_r;
      d3_fw_r    <= d2_fw_r;
      d3_degen_r <= d2_degen_r;

      d4_sdot_r  <= d3_sdot_r;
      d4_udot_r  <= DOTW'(d3_ue_r[0]) + DOTW'(d3_ue_r[1]) + DOTW'(d3_ue_r[2]);
      d4_fdot_r  <= d3_fdot_r;
      d4_uu_r    <= d3_uu_r;
      d4_sd_r    <= d3_sd_r;
      d4_fw_r    <= d3_fw_r;
      d4_degen_r <= d3_degen_r;

      fin_tr_r[0] <= sat_neg(rnd_shift(d4_sdot_r));
      fin_tr_r[1] <= sat_neg(rnd_shift(d4_udot_r));
      fin_tr_r[2] <= sat_neg(rnd_shift(d4_fdot_r));
      fin_uu_r    <= d4_uu_r;
      fin_sd_r    <= d4_sd_r;
      fin_fw_r    <= d4_fw_r;
      fin_degen_r <= d4_degen_r;
    end
  end

  // Row counter: steps on every result transfer and wraps after the
  // translation row, which is also what frees the final stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= 2'd0;
    end else if (fin_vld_r && !out_stall) begin
      row_r <= row_r + 2'd1;
    end
  end

  always_comb begin
    out_item.row_index  = row_r;
    out_item.degenerate = fin_degen_r;
    out_item.last_row   = (row_r == 2'd3);
    case (row_r) inside
      2'd0, 2'd1, 2'd2: begin
        out_item.element_a = DW'(fin_sd_r[row_r]);
        out_item.element_b = DW'(fin_uu_r[row_r]);
        out_item.element_c = DW'(fin_fw_r[row_r]);
      end
      default: begin
        out_item.element_a = fin_tr_r[0];
        out_item.element_b = fin_tr_r[1];
        out_item.element_c = fin_tr_r[2];
      end
    endcase
  end

  assign out_valid = fin_vld_r;

endmodule

// ===== rtl/lav_norm.sv =====
// Pipelined vector normalizer: scale, sum of squares, square root, three dividers.
// Depends on lav_pkg; instantiated twice by look_at_view_matrix.
module lav_norm (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  lav_pkg::vec_t  [2:0]   in_vec,
  input  lav_pkg::side_t         in_side,
  output logic                   out_vld,
  output lav_pkg::unit_t [2:0]   out_unit,
  output logic                   out_zero,
  output lav_pkg::side_t         out_side
);
  import lav_pkg::*;

  typedef struct packed {
    logic [2:0][MW-1:0] m;
    logic [2:0]         sgn;
    logic               zero;
    side_t              side;
  } nrm_carry_t;

  // Stage 1: magnitudes and the largest of them.
  logic               v1_r;
  logic [2:0][VW-1:0] mag1_r, mag1_nxt;
  logic [2:0]         sgn1_r;
  logic [VW-1:0]      mx1_r, mx1_nxt;
  side_t              side1_r;

  always_comb begin
    mx1_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      mag1_nxt[i] = in_vec[i][VW-1] ? VW'(-in_vec[i]) : VW'(in_vec[i]);
      if (mag1_nxt[i] > mx1_nxt) mx1_nxt = mag1_nxt[i];
    end
  end

  // Stage 2: position of the leading one.
  logic               v2_r;
  logic [2:0][VW-1:0] mag2_r;
  logic [2:0]         sgn2_r;
  logic [PW-1:0]      pos2_r, pos2_nxt;
  logic               zero2_r;
  side_t              side2_r;

  always_comb begin
    pos2_nxt = '0;
    for (int i = 0; i < VW; i++) begin
      if (mx1_r[i]) pos2_nxt = PW'(i);
    end
  end

  // Stage 3: shift so the largest magnitude has its top bit at MW-1.
  logic        v3_r;
  nrm_carry_t  c3_r, c3_nxt;
  logic [VW-1:0] wide3;

  always_comb begin
    wide3 = '0;
    c3_nxt.sgn  = sgn2_r;
    c3_nxt.zero = zero2_r;
    c3_nxt.side = side2_r;
    for (int i = 0; i < 3; i++) begin
      if (pos2_r >= PW'(MW - 1)) begin
        wide3 = mag2_r[i] >> (pos2_r - PW'(MW - 1));
      end else begin
        wide3 = mag2_r[i] << (PW'(MW - 1) - pos2_r);
      end
      c3_nxt.m[i] = wide3[MW-1:0];
    end
  end

  // Stage 4: squares.
  logic                 v4_r;
  nrm_carry_t           c4_r;
  logic [2:0][2*MW-1:0] sqp4_r, sqp4_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqp4_nxt[i] = c3_r.m[i] * c3_r.m[i];
    end
  end

  // Square root, one result bit per stage; entry 0 holds the sum of squares.
  logic             sq_v_r   [0:SQSTEPS];
  logic [SQW-1:0]   sq_n_r   [0:SQSTEPS];
  logic [SQW-1:0]   sq_res_r [0:SQSTEPS];
  nrm_carry_t       sq_c_r   [0:SQSTEPS];
  logic [SQW-1:0]   sq_n_nxt   [1:SQSTEPS];
  logic [SQW-1:0]   sq_res_nxt [1:SQSTEPS];
  logic [SQW-1:0]   sq_trial   [1:SQSTEPS];

  always_comb begin
    for (int k = 0; k < SQSTEPS; k++) begin
      sq_trial[k+1] = sq_res_r[k] + (SQW'(1) << (2 * (SQSTEPS - 1 - k)));
      if (sq_n_r[k] >= sq_trial[k+1]) begin
        sq_n_nxt[k+1]   = sq_n_r[k] - sq_trial[k+1];
        sq_res_nxt[k+1] = (sq_res_r[k] >> 1) + (SQW'(1) << (2 * (SQSTEPS - 1 - k)));
      end else begin
        sq_n_nxt[k+1]   = sq_n_r[k];
        sq_res_nxt[k+1] = sq_res_r[k] >> 1;
      end
    end
  end

  // Restoring division, one quotient bit per stage; entry 0 holds the rounded dividend.
  logic                     dv_v_r   [0:QBITS];
  logic [2:0][NUMW-1:0]     dv_rem_r [0:QBITS];
  logic [2:0][QBITS-1:0]    dv_q_r   [0:QBITS];
  logic [LW-1:0]            dv_len_r [0:QBITS];
  nrm_carry_t               dv_c_r   [0:QBITS];
  logic [2:0][NUMW-1:0]     dv_rem_nxt [1:QBITS];
  logic [2:0][QBITS-1:0]    dv_q_nxt   [1:QBITS];
  logic [NUMW-1:0]          dv_d       [1:QBITS];
  logic [LW-1:0]            len0;
  logic [2:0][NUMW-1:0]     rem0_nxt;

  always_comb begin
    len0 = sq_res_r[SQSTEPS][LW-1:0];
    for (int i = 0; i < 3; i++) begin
      rem0_nxt[i] = NUMW'({sq_c_r[SQSTEPS].m[i], {FRAC_BITS{1'b0}}}) + NUMW'(len0 >> 1);
    end
  end

  always_comb begin
    for (int j = 0; j < QBITS; j++) begin
      dv_d[j+1]       = NUMW'(dv_len_r[j]) << (QBITS - 1 - j);
      dv_rem_nxt[j+1] = dv_rem_r[j];
      dv_q_nxt[j+1]   = dv_q_r[j];
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_r[j][i] >= dv_d[j+1]) begin
          dv_rem_nxt[j+1][i] = dv_rem_r[j][i] - dv_d[j+1];
          dv_q_nxt[j+1][i][QBITS-1-j] = 1'b1;
        end
      end
    end
  end

  // Final stage: apply signs; a zero vector gives a zero result.
  logic             vo_r;
  unit_t [2:0]      unit_r, unit_nxt;
  logic             zero_r;
  side_t            side_r;
  nrm_carry_t       cf;

  always_comb begin
    cf = dv_c_r[QBITS];
    for (int i = 0; i < 3; i++) begin
      if (cf.zero) begin
        unit_nxt[i] = '0;
      end else if (cf.sgn[i]) begin
        unit_nxt[i] = -$signed({1'b0, dv_q_r[QBITS][i]});
      end else begin
        unit_nxt[i] = $signed({1'b0, dv_q_r[QBITS][i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
      for (int k = 0; k <= SQSTEPS; k++) sq_v_r[k] <= 1'b0;
      for (int j = 0; j <= QBITS; j++) dv_v_r[j] <= 1'b0;
    end else if (en) begin
      v1_r      <= in_vld;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      sq_v_r[0] <= v4_r;
      for (int k = 0; k < SQSTEPS; k++) sq_v_r[k+1] <= sq_v_r[k];
      dv_v_r[0] <= sq_v_r[SQSTEPS];
      for (int j = 0; j < QBITS; j++) dv_v_r[j+1] <= dv_v_r[j];
      vo_r      <= dv_v_r[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r  <= mag1_nxt;
      mx1_r   <= mx1_nxt;
      side1_r <= in_side;
      for (int i = 0; i < 3; i++) sgn1_r[i] <= in_vec[i][VW-1];

      mag2_r  <= mag1_r;
      sgn2_r  <= sgn1_r;
      pos2_r  <= pos2_nxt;
      zero2_r <= (mx1_r == '0);
      side2_r <= side1_r;

      c3_r   <= c3_nxt;
      c4_r   <= c3_r;
      sqp4_r <= sqp4_nxt;

      sq_n_r[0]   <= SQW'(sqp4_r[0]) + SQW'(sqp4_r[1]) + SQW'(sqp4_r[2]);
      sq_res_r[0] <= '0;
      sq_c_r[0]   <= c4_r;
      for (int k = 0; k < SQSTEPS; k++) begin
        sq_n_r[k+1]   <= sq_n_nxt[k+1];
        sq_res_r[k+1] <= sq_res_nxt[k+1];
        sq_c_r[k+1]   <= sq_c_r[k];
      end

      dv_rem_r[0] <= rem0_nxt;
      dv_q_r[0]   <= '0;
      dv_len_r[0] <= len0;
      dv_c_r[0]   <= sq_c_r[SQSTEPS];
      for (int j = 0; j < QBITS; j++) begin
        dv_rem_r[j+1] <= dv_rem_nxt[j+1];
        dv_q_r[j+1]   <= dv_q_nxt[j+1];
        dv_len_r[j+1] <= dv_len_r[j];
        dv_c_r[j+1]   <= dv_c_r[j];
      end

      unit_r <= unit_nxt;
      zero_r <= cf.zero;
      side_r <= cf.side;
    end
  end

  assign out_vld  = vo_r;
  assign out_unit = unit_r;
  assign out_zero = zero_r;
  assign out_side = side_r;

endmodule

// ===== rtl/lav_checker.sv =====
// Port-level checks on the result channel of look_at_view_matrix.
// Depends on lav_pkg; attached to the top level by the bind at the end.
module lav_port_props (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input lav_pkg::out_item_t out_item
);
  import lav_pkg::*;

  // The rows of one item follow each other without a gap.
  a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.last_row |=> out_valid)
    else $error("row sequence broken by a gap");

  // Row numbers count up by one within an item.
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.last_row |=>
      out_item.row_index == $past(out_item.row_index) + 2'd1)
    else $error("row index did not step by one");

  // The final-row flag marks the translation row and no other.
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last_row == (out_item.row_index == 2'd3)))
    else $error("last_row does not match row_index");

  // The degenerate flag is one value for all rows of an item.
  a_degen_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.last_row |=> $stable(out_item.degenerate))
    else $error("degenerate changed within an item");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind look_at_view_matrix lav_port_props u_lav_port_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
